@@ design/slae_pkg.sv @@
// Shared constants and types for the shifting array list engine.
`default_nettype none
package slae_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OPW  = 2;
  localparam int POSW = 5;
  localparam int STW  = 2;
  localparam int CNTW = 5;
  localparam int FPW  = 5;
  localparam int APBW = 32;
  localparam int ADDRW = 3;

  localparam logic [OPW-1:0] OP_APPEND = 2'd0;
  localparam logic [OPW-1:0] OP_INSERT = 2'd1;
  localparam logic [OPW-1:0] OP_DELETE = 2'd2;
  localparam logic [OPW-1:0] OP_SEARCH = 2'd3;

  localparam logic [STW-1:0] ST_OK       = 2'd0;
  localparam logic [STW-1:0] ST_REJECT   = 2'd1;
  localparam logic [STW-1:0] ST_NOTFOUND = 2'd2;

  localparam logic [FPW-1:0] FOUND_NONE = 5'h1F;

  localparam logic [CNTW-1:0] CAPACITY_RESET = 5'd16;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ design/shifting_array_list_engine.sv @@
// Top level of the shifting array list engine: control, cell chain and register port.
// Append, insert and delete need no rotation; done pulses the cycle after start.
// Search rotates the chain once through cell 0; busy stays high for the whole rotation and falls as done pulses.
// A new transaction is taken whenever busy is low; the receiver cannot stall results.
// Reset empties the list and sets capacity to 16; stored entries are not cleared.
`default_nettype none
module shifting_array_list_engine #(
  parameter int DEPTH      = slae_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = slae_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [slae_pkg::ADDRW-1:0]  paddr,
  input  wire logic [slae_pkg::APBW-1:0]   pwdata,
  output logic      [slae_pkg::APBW-1:0]   prdata,
  output logic                             pready,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [slae_pkg::OPW-1:0]    opcode,
  input  wire logic [slae_pkg::POSW-1:0]   position_in,
  input  wire logic signed [DATA_WIDTH-1:0] value_in,
  output logic                             done,
  output logic      [slae_pkg::STW-1:0]    status,
  output logic signed [slae_pkg::FPW-1:0]  found_position,
  output logic signed [DATA_WIDTH-1:0]     removed_value,
  output logic      [slae_pkg::CNTW-1:0]   count_out
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > slae_pkg::POSW) ? CW : slae_pkg::POSW;
  localparam logic [CMPW-1:0] DEPTH_C   = CMPW'(DEPTH);
  localparam logic [IW-1:0]   SCAN_LAST = IW'(DEPTH - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                           state;
  logic [CW-1:0]                  count;
  logic [slae_pkg::CNTW-1:0]      capacity;
  logic [IW-1:0]                  scan_cnt;
  logic                           hit;
  logic [IW-1:0]                  hit_pos;
  logic [DATA_WIDTH-1:0]          key;

  logic [DATA_WIDTH-1:0]          cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]          sel_data  [DEPTH];
  slae_pkg::cell_ctl_t            cell_ctl  [DEPTH];

  logic                  accept;
  logic                  scanning;
  logic [CMPW-1:0]       count_ext;
  logic [CMPW-1:0]       pos_ext;
  logic [CMPW-1:0]       cap_ext;
  logic [CMPW-1:0]       limit_ext;
  logic [CMPW-1:0]       scan_ext;
  logic                  full;
  logic                  ins_ok;
  logic                  del_ok;
  logic                  do_append;
  logic                  do_insert;
  logic                  do_delete;
  logic                  match;
  logic                  cfg_write;
  logic [DATA_WIDTH-1:0] removed_sel;

  assign pready    = 1'b1;
  assign prdata    = slae_pkg::APBW'(capacity);
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == slae_pkg::REG_CAPACITY);

  assign scanning  = (state == S_SCAN);
  assign busy      = scanning;
  assign accept    = start && !busy;

  assign count_ext = CMPW'(count);
  assign pos_ext   = CMPW'(position_in);
  assign cap_ext   = CMPW'(capacity);
  assign limit_ext = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
  assign scan_ext  = CMPW'(scan_cnt);

  assign full      = (count_ext >= limit_ext);
  assign ins_ok    = !full && (pos_ext <= count_ext);
  assign del_ok    = (pos_ext < count_ext);

  assign do_append = accept && (opcode == slae_pkg::OP_APPEND) && !full;
  assign do_insert = accept && (opcode == slae_pkg::OP_INSERT) && ins_ok;
  assign do_delete = accept && (opcode == slae_pkg::OP_DELETE) && del_ok;

  assign match = scanning && !hit && (scan_ext < count_ext) && (cell_data[0] == key);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMPW-1:0] IDX = CMPW'(i);
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_data[0];
    end else begin : g_upper
      assign upper = cell_data[i+1];
    end

    assign cell_ctl[i].load       = (do_append && (IDX == count_ext)) ||
                                    (do_insert && (IDX == pos_ext));
    assign cell_ctl[i].shift_up   = do_insert && (IDX > pos_ext);
    assign cell_ctl[i].shift_down = (do_delete && (IDX >= pos_ext)) || scanning;
    assign sel_data[i]            = (IDX == pos_ext) ? cell_data[i] : '0;

    slae_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .load_data (value_in),
      .lower_data(lower),
      .upper_data(upper),
      .data      (cell_data[i])
    );
  end

  always_comb begin
    removed_sel = '0;
    for (int k = 0; k < DEPTH; k++) begin
      removed_sel = removed_sel | sel_data[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      capacity <= slae_pkg::CAPACITY_RESET;
      done     <= 1'b0;
      hit      <= 1'b0;
      scan_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        capacity <= pwdata[slae_pkg::CNTW-1:0];
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == slae_pkg::OP_SEARCH) begin
              state    <= S_SCAN;
              hit      <= 1'b0;
              scan_cnt <= '0;
            end else begin
              done <= 1'b1;
              if (do_append || do_insert) begin
                count <= count + CW'(1);
              end else if (do_delete) begin
                count <= count - CW'(1);
              end
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            hit <= 1'b1;
          end
          scan_cnt <= scan_cnt + IW'(1);
          if (scan_cnt == SCAN_LAST) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (opcode == slae_pkg::OP_SEARCH)) begin
      key <= value_in;
    end
    if (match) begin
      hit_pos <= scan_cnt;
    end
    if (accept && (opcode != slae_pkg::OP_SEARCH)) begin
      found_position <= slae_pkg::FOUND_NONE;
      removed_value  <= do_delete ? removed_sel : '0;
      if (do_append || do_insert) begin
        status    <= slae_pkg::ST_OK;
        count_out <= slae_pkg::CNTW'(count + CW'(1));
      end else if (do_delete) begin
        status    <= slae_pkg::ST_OK;
        count_out <= slae_pkg::CNTW'(count - CW'(1));
      end else begin
        status    <= slae_pkg::ST_REJECT;
        count_out <= slae_pkg::CNTW'(count);
      end
    end else if (scanning && (scan_cnt == SCAN_LAST)) begin
      removed_value <= '0;
      count_out     <= slae_pkg::CNTW'(count);
      if (hit) begin
        status         <= slae_pkg::ST_OK;
        found_position <= slae_pkg::FPW'(hit_pos);
      end else if (match) begin
        status         <= slae_pkg::ST_OK;
        found_position <= slae_pkg::FPW'(scan_cnt);
      end else begin
        status         <= slae_pkg::ST_NOTFOUND;
        found_position <= slae_pkg::FOUND_NONE;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count_ext <= DEPTH_C)
    else $error("List count exceeds the store depth.");

  a_quick_op_done: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode != slae_pkg::OP_SEARCH)) |=> done)
    else $error("Non-search transaction did not complete in one cycle.");

  a_scan_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (scanning && (scan_cnt != SCAN_LAST)) |=> !done)
    else $error("Search result issued before the rotation finished.");

  a_scan_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (scanning && $past(scanning)) |-> $stable(count))
    else $error("List count changed during a search.");
`endif

endmodule
`default_nettype wire

@@ design/slae_cell.sv @@
// One storage cell of the list chain: holds an entry, loads a new one or takes data from a neighbor.
`default_nettype none
module slae_cell #(
  parameter int DATA_WIDTH = slae_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire slae_pkg::cell_ctl_t   ctl,
  input  wire logic [DATA_WIDTH-1:0] load_data,
  input  wire logic [DATA_WIDTH-1:0] lower_data,
  input  wire logic [DATA_WIDTH-1:0] upper_data,
  output logic      [DATA_WIDTH-1:0] data
);

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    priority if (ctl.load) begin
      data_next = load_data;
    end else if (ctl.shift_up) begin
      data_next = lower_data;
    end else if (ctl.shift_down) begin
      data_next = upper_data;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire
